// File: src/ffa_pkg.sv
// Shared constants and codes for the first-fit allocator.
package ffa_pkg;

   localparam int ID_W     = 16;
   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 16;

   localparam logic [CSR_W-1:0] MEM_SIZE_RESET = 16'd1024;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SKIP     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

endpackage

// File: src/ffa_if.sv
// Request and response channel interfaces of the allocator.
interface ffa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [ffa_pkg::ID_W-1:0]    owner_id;
   logic [ffa_pkg::SIZE_W-1:0]  request_size;

   modport source (output valid, action, owner_id, request_size, input ready);
   modport sink   (input valid, action, owner_id, request_size, output ready);
endinterface

interface ffa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffa_pkg::STATUS_W-1:0]  status;
   logic [ffa_pkg::ADDR_W-1:0]    base_address;
   logic [ffa_pkg::ADDR_W-1:0]    end_address;
   logic [ffa_pkg::SIZE_W-1:0]    used_units;

   modport source (output valid, status, base_address, end_address, used_units,
                   input ready);
   modport sink   (input valid, status, base_address, end_address, used_units,
                   output ready);
endinterface

// File: src/first_fit_allocator_unit.sv
// First-fit allocator: top level with request control and skip-id store.
//
// Usage:
//  req_chan carries one request (action, owner_id, request_size) per
//  valid/ready handshake; rsp_chan returns exactly one response per request
//  (status, base_address, end_address, used_units) in request order.
//  csr_we/csr_wdata write memory_size; a write restarts the table as reset does.
//  An allocate walks the segment table from entry 0 at one entry per
//  cycle until the first fit, then moves the tail up one entry per cycle on a
//  split; a free first walks the skip-id list (one id per cycle), then the
//  segment table, then moves the tail down one entry per cycle on a merge.
//  The worst case is a free that walks a full skip-id list and then a full
//  table up to its hit and on through the tail move; the memory walks set
//  its length. One request is in work at a time; req_chan.ready is high
//  only when idle. Reset (and a csr write) passes through S_INIT, which
//  writes the initial free segment, with req_chan.ready low. A response held
//  by a stalled receiver sits in the output register; the next request is
//  still taken and its result waits until the register frees up.
module first_fit_allocator_unit #(
   parameter int MAX_SEGMENTS = 64,
   parameter int SKIP_DEPTH   = 64,
   parameter int ADDR_BITS    = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   ffa_req_if.sink                    req_chan,
   ffa_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [ffa_pkg::CSR_W-1:0]  csr_wdata
);
   import ffa_pkg::*;

   localparam int CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int IW  = $clog2(MAX_SEGMENTS);
   localparam int SCW = $clog2(SKIP_DEPTH + 1);
   localparam int SIW = (SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1;
   localparam int SW  = (ADDR_BITS + 1 > 17) ? ADDR_BITS + 1 : 17;
   localparam int DW  = 2 * ADDR_BITS + ID_W + 1;

   typedef struct packed {
      logic                 is_free;
      logic [ID_W-1:0]      owner;
      logic [ADDR_BITS-1:0] last;
      logic [ADDR_BITS-1:0] first;
   } seg_type;

   typedef enum logic [9:0] {
      S_INIT  = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_SKSCN = 10'b0000000100,
      S_SCAN  = 10'b0000001000,
      S_NEXT  = 10'b0000010000,
      S_SHUP  = 10'b0000100000,
      S_WRLO  = 10'b0001000000,
      S_WRHI  = 10'b0010000000,
      S_SHDN  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      msize_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]         used_ff, used_in;
   logic [SCW-1:0]        skcnt_ff, skcnt_in;
   logic                  act_ff, act_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [SIZE_W-1:0]     req_ff, req_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         dix_ff, dix_in;
   logic                  dvld_ff, dvld_in;
   logic [SCW-1:0]        sptr_ff, sptr_in;
   logic [SCW-1:0]        sdix_ff, sdix_in;
   logic [CW-1:0]         hit_ff, hit_in;
   seg_type               seg_ff, seg_in;
   seg_type               prev_ff, prev_in;
   logic [1:0]            rmv_ff, rmv_in;
   logic [CW-1:0]         wa_ff, wa_in;
   logic [STATUS_W-1:0]   res_st_ff, res_st_in;
   logic [ADDR_BITS-1:0]  res_base_ff, res_base_in;
   logic [ADDR_BITS-1:0]  res_last_ff, res_last_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [STATUS_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [ADDR_W-1:0]     rsp_base_ff, rsp_base_in;
   logic [ADDR_W-1:0]     rsp_last_ff, rsp_last_in;
   logic [SIZE_W-1:0]     rsp_used_ff, rsp_used_in;

   // segment memory port
   logic                  seg_we;
   logic [IW-1:0]         seg_wa;
   seg_type               seg_wd;
   logic [IW-1:0]         seg_ra;
   logic [DW-1:0]         seg_rd_raw;
   seg_type               rd;

   // skip-id store
   logic [ID_W-1:0]       skip_mem [2**SIW];
   logic [ID_W-1:0]       sk_rd_ff;
   logic                  sk_we;
   logic [ID_W-1:0]       sk_wd;
   logic [SIW-1:0]        sk_ra;

   // misc combinational
   logic [SW-1:0]         msz_w, lim_w, eff_w;
   logic [SW-1:0]         req_w, seg_size;
   logic                  skip_now;
   logic                  nb_free, pv_free;
   logic [ADDR_BITS-1:0]  merge_last;
   logic                  issue;
   logic                  req_fire;

   ffa_seg_ram #(
      .DEPTH (MAX_SEGMENTS),
      .AW    (IW),
      .DW    (DW)
   ) u_seg_ram (
      .clock      (clock),
      .wr_en      (seg_we),
      .wr_addr    (seg_wa),
      .wr_data    (seg_wd),
      .rd_addr    (seg_ra),
      .rd_data_ff (seg_rd_raw)
   );

   assign rd = seg_type'(seg_rd_raw);

   // effective memory size: zero counts as one, clamp to the address space
   always_comb begin
      msz_w = SW'(msize_ff);
      lim_w = SW'(1) << ADDR_BITS;
      if (msize_ff == '0) begin
         eff_w = SW'(1);
      end else if (msz_w > lim_w) begin
         eff_w = lim_w;
      end else begin
         eff_w = msz_w;
      end
   end

   assign req_w    = SW'(req_ff);
   assign seg_size = SW'(rd.last) - SW'(rd.first) + SW'(1);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.status       = rsp_st_ff;
   assign rsp_chan.base_address = rsp_base_ff;
   assign rsp_chan.end_address  = rsp_last_ff;
   assign rsp_chan.used_units   = rsp_used_ff;

   // request control
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      used_in     = used_ff;
      skcnt_in    = skcnt_ff;
      act_in      = act_ff;
      id_in       = id_ff;
      req_in      = req_ff;
      ptr_in      = ptr_ff;
      dix_in      = dix_ff;
      dvld_in     = dvld_ff;
      sptr_in     = sptr_ff;
      sdix_in     = sdix_ff;
      hit_in      = hit_ff;
      seg_in      = seg_ff;
      prev_in     = prev_ff;
      rmv_in      = rmv_ff;
      wa_in       = wa_ff;
      res_st_in   = res_st_ff;
      res_base_in = res_base_ff;
      res_last_in = res_last_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      rsp_st_in   = rsp_st_ff;
      rsp_base_in = rsp_base_ff;
      rsp_last_in = rsp_last_ff;
      rsp_used_in = rsp_used_ff;
      seg_we      = 1'b0;
      seg_wa      = wa_ff[IW-1:0];
      seg_wd      = rd;
      seg_ra      = ptr_ff[IW-1:0];
      sk_we       = 1'b0;
      sk_wd       = id_ff;
      sk_ra       = sptr_ff[SIW-1:0];
      skip_now    = 1'b0;
      nb_free     = 1'b0;
      pv_free     = 1'b0;
      merge_last  = seg_ff.last;
      issue       = 1'b0;

      case (state_ff)
         S_INIT: begin
            seg_we   = 1'b1;
            seg_wa   = '0;
            seg_wd   = '{is_free: 1'b1, owner: '0,
                         last: ADDR_BITS'(eff_w - SW'(1)), first: '0};
            cnt_in   = CW'(1);
            used_in  = '0;
            skcnt_in = '0;
            state_in = S_IDLE;
         end

         S_IDLE: begin
            if (req_fire) begin
               act_in      = req_chan.action;
               id_in       = req_chan.owner_id;
               req_in      = req_chan.request_size;
               res_base_in = '0;
               res_last_in = '0;
               ptr_in      = '0;
               sptr_in     = '0;
               dvld_in     = 1'b0;
               if (req_chan.action == ACT_ALLOC) begin
                  if (used_ff < eff_w && req_chan.request_size != '0) begin
                     state_in = S_SCAN;
                  end else begin
                     sk_wd    = req_chan.owner_id;
                     skip_now = 1'b1;
                  end
               end else if (skcnt_ff == '0) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_SKSCN;
               end
            end
         end

         // walk the skip-id list
         S_SKSCN: begin
            sptr_in = sptr_ff + SCW'(1);
            sdix_in = sptr_ff;
            dvld_in = 1'b1;
            if (dvld_ff) begin
               if (sdix_ff == skcnt_ff) begin
                  state_in = S_SCAN;
                  ptr_in   = '0;
                  dvld_in  = 1'b0;
               end else if (sk_rd_ff == id_ff) begin
                  res_st_in = ST_IGNORED;
                  state_in  = S_DONE;
               end
            end
         end

         // walk the segment table in address order
         S_SCAN: begin
            ptr_in  = ptr_ff + CW'(1);
            dix_in  = ptr_ff;
            dvld_in = 1'b1;
            if (dvld_ff) begin
               if (dix_ff >= cnt_ff) begin
                  if (act_ff == ACT_ALLOC) begin
                     skip_now = 1'b1;
                  end else begin
                     res_st_in = ST_NOTFOUND;
                     state_in  = S_DONE;
                  end
               end else if (act_ff == ACT_ALLOC) begin
                  if (rd.is_free && seg_size >= req_w) begin
                     hit_in      = dix_ff;
                     res_base_in = rd.first;
                     res_last_in = ADDR_BITS'(SW'(rd.first) + req_w - SW'(1));
                     if (seg_size == req_w) begin
                        seg_we    = 1'b1;
                        seg_wa    = dix_ff[IW-1:0];
                        seg_wd    = '{is_free: 1'b0, owner: id_ff,
                                      last: rd.last, first: rd.first};
                        used_in   = used_ff + req_w;
                        res_st_in = ST_ALLOC;
                        state_in  = S_DONE;
                     end else if (cnt_ff < CW'(MAX_SEGMENTS)) begin
                        seg_in    = rd;
                        used_in   = used_ff + req_w;
                        res_st_in = ST_ALLOC;
                        ptr_in    = cnt_ff - CW'(1);
                        dvld_in   = 1'b0;
                        state_in  = S_SHUP;
                     end else begin
                        res_base_in = '0;
                        res_last_in = '0;
                        skip_now    = 1'b1;
                     end
                  end else begin
                     prev_in = rd;
                  end
               end else begin
                  if (!rd.is_free && rd.owner == id_ff) begin
                     seg_in      = rd;
                     hit_in      = dix_ff;
                     res_base_in = rd.first;
                     res_last_in = rd.last;
                     used_in     = used_ff - seg_size;
                     res_st_in   = ST_FREED;
                     state_in    = S_NEXT;
                  end else begin
                     prev_in = rd;
                  end
               end
            end
         end

         // read data now holds the entry after the freed one
         S_NEXT: begin
            nb_free    = (SW'(hit_ff) + SW'(1) < SW'(cnt_ff)) && rd.is_free;
            pv_free    = (hit_ff != '0) && prev_ff.is_free;
            merge_last = nb_free ? rd.last : seg_ff.last;
            seg_we     = 1'b1;
            dvld_in    = 1'b0;
            if (pv_free) begin
               seg_wa = IW'(hit_ff - CW'(1));
               seg_wd = '{is_free: 1'b1, owner: '0, last: merge_last,
                          first: prev_ff.first};
               rmv_in = nb_free ? 2'd2 : 2'd1;
               ptr_in = hit_ff + (nb_free ? CW'(2) : CW'(1));
            end else begin
               seg_wa = hit_ff[IW-1:0];
               seg_wd = '{is_free: 1'b1, owner: '0, last: merge_last,
                          first: seg_ff.first};
               rmv_in = nb_free ? 2'd1 : 2'd0;
               ptr_in = hit_ff + CW'(2);
            end
            if (!pv_free && !nb_free) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SHDN;
            end
         end

         // move the tail down over removed entries
         S_SHDN: begin
            issue   = ptr_ff < cnt_ff;
            dvld_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + CW'(1);
               wa_in  = ptr_ff - CW'(rmv_ff);
            end
            if (dvld_ff) begin
               seg_we = 1'b1;
            end
            if (!issue && !dvld_ff) begin
               cnt_in   = cnt_ff - CW'(rmv_ff);
               state_in = S_DONE;
            end
         end

         // move the tail up one entry to open a slot for the split
         S_SHUP: begin
            issue   = ptr_ff > hit_ff;
            dvld_in = issue;
            if (issue) begin
               ptr_in = ptr_ff - CW'(1);
               wa_in  = ptr_ff + CW'(1);
            end
            if (dvld_ff) begin
               seg_we = 1'b1;
            end
            if (!issue && !dvld_ff) begin
               state_in = S_WRLO;
            end
         end

         S_WRLO: begin
            seg_we   = 1'b1;
            seg_wa   = hit_ff[IW-1:0];
            seg_wd   = '{is_free: 1'b0, owner: id_ff, last: res_last_ff,
                         first: seg_ff.first};
            state_in = S_WRHI;
         end

         S_WRHI: begin
            seg_we   = 1'b1;
            seg_wa   = IW'(hit_ff + CW'(1));
            seg_wd   = '{is_free: 1'b1, owner: '0, last: seg_ff.last,
                         first: res_last_ff + ADDR_BITS'(1)};
            cnt_in   = cnt_ff + CW'(1);
            state_in = S_DONE;
         end

         // hand the result to the output register
         S_DONE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_st_in   = res_st_ff;
               rsp_base_in = ADDR_W'(res_base_ff);
               rsp_last_in = ADDR_W'(res_last_ff);
               rsp_used_in = SIZE_W'(used_ff);
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase

      // skipped allocation: record id while there is room
      if (skip_now) begin
         res_st_in   = ST_SKIP;
         res_base_in = '0;
         res_last_in = '0;
         state_in    = S_DONE;
         if (skcnt_ff < SCW'(SKIP_DEPTH)) begin
            sk_we    = 1'b1;
            skcnt_in = skcnt_ff + SCW'(1);
         end
      end
   end

   // skip-id store
   always_ff @(posedge clock) begin
      if (sk_we) begin
         skip_mem[skcnt_ff[SIW-1:0]] <= sk_wd;
      end
      sk_rd_ff <= skip_mem[sk_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         msize_ff   <= MEM_SIZE_RESET;
         cnt_ff     <= CW'(1);
         used_ff    <= '0;
         skcnt_ff   <= '0;
         dvld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (csr_we) begin
         state_ff   <= S_INIT;
         msize_ff   <= csr_wdata;
         dvld_ff    <= 1'b0;
         rsp_vld_ff <= rsp_vld_in;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         used_ff    <= used_in;
         skcnt_ff   <= skcnt_in;
         dvld_ff    <= dvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      id_ff       <= id_in;
      req_ff      <= req_in;
      ptr_ff      <= ptr_in;
      dix_ff      <= dix_in;
      sptr_ff     <= sptr_in;
      sdix_ff     <= sdix_in;
      hit_ff      <= hit_in;
      seg_ff      <= seg_in;
      prev_ff     <= prev_in;
      rmv_ff      <= rmv_in;
      wa_ff       <= wa_in;
      res_st_ff   <= res_st_in;
      res_base_ff <= res_base_in;
      res_last_ff <= res_last_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_base_ff <= rsp_base_in;
      rsp_last_ff <= rsp_last_in;
      rsp_used_ff <= rsp_used_in;
   end
endmodule

// File: src/ffa_seg_ram.sv
// Segment table storage: one write port, one registered read port.
module ffa_seg_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 49
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data_ff
);
   logic [DW-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end
endmodule

// File: test/tb_first_fit_allocator_unit.sv
// Self-checking testbench for the first-fit allocator unit.
`timescale 1ns / 1ps

module tb_first_fit_allocator_unit;
   import ffa_pkg::*;

   localparam int NUM_SEGS     = 64;
   localparam int NUM_SKIPS    = 64;
   localparam int STALL_LIMIT  = 5000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   base_address;
      logic [ADDR_W-1:0]   end_address;
      logic [SIZE_W-1:0]   used_units;
   } alloc_result_t;

   typedef struct packed {
      logic              action;
      logic [ID_W-1:0]   owner_id;
      logic [SIZE_W-1:0] request_size;
      logic              typed;
      alloc_result_t     result;
   } directed_row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_W-1:0] csr_wdata;

   ffa_req_if req_bus ();
   ffa_rsp_if rsp_bus ();

   first_fit_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the segment table and skipped-id list
   int unsigned seg_lo [NUM_SEGS];
   int unsigned seg_hi [NUM_SEGS];
   int unsigned seg_own [NUM_SEGS];
   bit          seg_free [NUM_SEGS];
   int unsigned seg_count;
   int unsigned units_in_use;
   int unsigned mem_units;
   int unsigned skip_ids [NUM_SKIPS];
   int unsigned skip_count;

   alloc_result_t pending_results[$];
   int idle_pct;
   int stall_pct;
   int error_count;
   int checked_count;
   int status_seen [5];
   int quiet_cycles;
   directed_row_t directed_rows [14];

   always #1 clock = ~clock;

   function automatic void restart_table(int unsigned size_reg);
      mem_units = (size_reg == 0) ? 1 : size_reg;
      seg_count = 1;
      seg_lo[0] = 0;
      seg_hi[0] = mem_units - 1;
      seg_own[0] = 0;
      seg_free[0] = 1'b1;
      units_in_use = 0;
      skip_count = 0;
   endfunction

   function automatic void drop_segment(int unsigned idx);
      int unsigned k;
      for (k = idx; k + 1 < seg_count; k++) begin
         seg_lo[k] = seg_lo[k+1];
         seg_hi[k] = seg_hi[k+1];
         seg_own[k] = seg_own[k+1];
         seg_free[k] = seg_free[k+1];
      end
      seg_count--;
   endfunction

   // Applies one request to the mirror and returns the response it must produce
   function automatic alloc_result_t apply_request(logic action, int unsigned id,
                                                   int unsigned size);
      alloc_result_t r;
      int unsigned i, k, span;
      bit hit;
      bit listed;
      r = '0;
      hit = 0;
      listed = 0;
      if (action == ACT_ALLOC) begin
         r.status = ST_SKIP;
         if (units_in_use < mem_units && size != 0) begin
            for (i = 0; i < seg_count && !hit; i++) begin
               if (!seg_free[i]) continue;
               span = seg_hi[i] - seg_lo[i] + 1;
               if (span < size) continue;
               hit = 1;
               if (span == size) begin
                  seg_free[i] = 0;
                  seg_own[i] = id;
               end else if (seg_count < NUM_SEGS) begin
                  for (k = seg_count; k > i; k--) begin
                     seg_lo[k] = seg_lo[k-1];
                     seg_hi[k] = seg_hi[k-1];
                     seg_own[k] = seg_own[k-1];
                     seg_free[k] = seg_free[k-1];
                  end
                  seg_count++;
                  seg_hi[i] = seg_lo[i] + size - 1;
                  seg_own[i] = id;
                  seg_free[i] = 0;
                  seg_lo[i+1] = seg_hi[i] + 1;
               end else begin
                  // first fit needs a split but the table is full
                  break;
               end
               r.base_address = ADDR_W'(seg_lo[i]);
               r.end_address = ADDR_W'(seg_hi[i]);
               units_in_use += size;
               r.status = ST_ALLOC;
            end
         end
         if (r.status == ST_SKIP && skip_count < NUM_SKIPS) begin
            skip_ids[skip_count] = id;
            skip_count++;
         end
      end else begin
         for (k = 0; k < skip_count; k++)
            if (skip_ids[k] == id) listed = 1;
         if (listed) begin
            r.status = ST_IGNORED;
         end else begin
            r.status = ST_NOTFOUND;
            for (i = 0; i < seg_count; i++)
               if (!seg_free[i] && seg_own[i] == id) break;
            if (i < seg_count) begin
               r.status = ST_FREED;
               r.base_address = ADDR_W'(seg_lo[i]);
               r.end_address = ADDR_W'(seg_hi[i]);
               units_in_use -= seg_hi[i] - seg_lo[i] + 1;
               seg_free[i] = 1;
               seg_own[i] = 0;
               if (i + 1 < seg_count && seg_free[i+1]) begin
                  seg_hi[i] = seg_hi[i+1];
                  drop_segment(i + 1);
               end
               if (i > 0 && seg_free[i-1]) begin
                  seg_hi[i-1] = seg_hi[i];
                  drop_segment(i);
               end
            end
         end
      end
      r.used_units = SIZE_W'(units_in_use);
      return r;
   endfunction

   // Drive one request; valid stays high after acceptance until the next decision
   task automatic send_request(logic action, logic [ID_W-1:0] id,
                               logic [SIZE_W-1:0] size, logic typed,
                               alloc_result_t typed_result);
      alloc_result_t r;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= action;
      req_bus.owner_id <= id;
      req_bus.request_size <= size;
      do @(posedge clock); while (!req_bus.ready);
      r = apply_request(action, 32'(id), 32'(size));
      pending_results.push_back(typed ? typed_result : r);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_mem_size(logic [CSR_W-1:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      restart_table(32'(value));
   endtask

   // Random requests: mostly a small id pool so frees find their blocks
   task automatic random_requests(int count);
      logic action;
      logic [ID_W-1:0] id;
      logic [SIZE_W-1:0] size;
      int unsigned pick;
      int unsigned top;
      top = (mem_units / 6 > 1) ? mem_units / 6 : 1;
      repeat (count) begin
         action = ($urandom_range(99) < 40) ? ACT_FREE : ACT_ALLOC;
         pick = $urandom_range(99);
         if (pick < 85) id = ID_W'($urandom_range(24, 1));
         else if (pick < 88) id = '0;
         else id = ID_W'($urandom_range(65535));
         pick = $urandom_range(99);
         if (pick < 82) size = SIZE_W'($urandom_range(top, 1));
         else if (pick < 86) size = '0;
         else if (pick < 92) size = SIZE_W'($urandom_range(3, 1));
         else size = SIZE_W'($urandom_range(65535));
         send_request(action, id, size, 1'b0, '0);
      end
   endtask

   // Response checker and stall watchdog
   always @(posedge clock) begin
      alloc_result_t want;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or response for %0d cycles", STALL_LIMIT);
            $display("tb_first_fit_allocator_unit failed");
            $finish;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("response with nothing pending: status %0d", rsp_bus.status);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               checked_count++;
               if (want.status < 5) status_seen[want.status]++;
               if (rsp_bus.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.base_address !== want.base_address) begin
                  $error("base_address expected %0d actual %0d",
                         want.base_address, rsp_bus.base_address);
                  error_count++;
               end
               if (rsp_bus.end_address !== want.end_address) begin
                  $error("end_address expected %0d actual %0d",
                         want.end_address, rsp_bus.end_address);
                  error_count++;
               end
               if (rsp_bus.used_units !== want.used_units) begin
                  $error("used_units expected %0d actual %0d",
                         want.used_units, rsp_bus.used_units);
                  error_count++;
               end
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      int n;
      int drain_cycles;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_ALLOC;
      req_bus.owner_id = '0;
      req_bus.request_size = '0;
      rsp_bus.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      error_count = 0;
      checked_count = 0;
      quiet_cycles = 0;
      status_seen = '{default: 0};
      restart_table(32'(MEM_SIZE_RESET));

      // action, id, size, typed, {status, base, end, used}
      directed_rows = '{
         '{ACT_ALLOC, 16'd1,     16'd0,     1'b1, '{ST_SKIP,     16'd0,   16'd0,    16'd0}},
         '{ACT_FREE,  16'd1,     16'd0,     1'b1, '{ST_IGNORED,  16'd0,   16'd0,    16'd0}},
         '{ACT_ALLOC, 16'd2,     16'd100,   1'b1, '{ST_ALLOC,    16'd0,   16'd99,   16'd100}},
         '{ACT_ALLOC, 16'd3,     16'hFFFF,  1'b1, '{ST_SKIP,     16'd0,   16'd0,    16'd100}},
         '{ACT_FREE,  16'd7,     16'hFFFF,  1'b1, '{ST_NOTFOUND, 16'd0,   16'd0,    16'd100}},
         '{ACT_ALLOC, 16'd4,     16'd924,   1'b1, '{ST_ALLOC,    16'd100, 16'd1023, 16'd1024}},
         '{ACT_ALLOC, 16'd5,     16'd1,     1'b1, '{ST_SKIP,     16'd0,   16'd0,    16'd1024}},
         '{ACT_FREE,  16'd2,     16'd0,     1'b1, '{ST_FREED,    16'd0,   16'd99,   16'd924}},
         '{ACT_FREE,  16'd0,     16'd0,     1'b1, '{ST_NOTFOUND, 16'd0,   16'd0,    16'd924}},
         '{ACT_ALLOC, 16'hFFFF,  16'd100,   1'b1, '{ST_ALLOC,    16'd0,   16'd99,   16'd1024}},
         '{ACT_FREE,  16'd4,     16'd0,     1'b1, '{ST_FREED,    16'd100, 16'd1023, 16'd100}},
         '{ACT_ALLOC, 16'h8000,  16'd1,     1'b0, '0},
         '{ACT_FREE,  16'hFFFF,  16'd0,     1'b0, '0},
         '{ACT_FREE,  16'h8000,  16'd0,     1'b0, '0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table at reset size, then random traffic with no idling
      foreach (directed_rows[i])
         send_request(directed_rows[i].action, directed_rows[i].owner_id,
                      directed_rows[i].request_size, directed_rows[i].typed,
                      directed_rows[i].result);
      random_requests(120);

      // Tiny memory with unit requests fills the table and the skip list
      write_mem_size(16'd64);
      idle_pct = 48;
      random_requests(160);
      wait_drained();
      for (n = 0; n < 70; n++)
         send_request(ACT_ALLOC, ID_W'($urandom_range(24, 1)), 16'd1, 1'b0, '0);

      // Largest memory, receiver stalling
      write_mem_size(16'hFFFF);
      idle_pct = 0;
      stall_pct = 48;
      random_requests(150);

      // Smallest memory, both sides idling a little
      write_mem_size(16'd1);
      idle_pct = 8;
      stall_pct = 8;
      random_requests(80);

      // Mid size, full rate with a drained pause in the middle
      write_mem_size(16'd300);
      idle_pct = 0;
      stall_pct = 0;
      random_requests(60);
      wait_drained();
      random_requests(60);

      wait_drained();
      drain_cycles = 0;
      while (drain_cycles < 300) begin
         @(posedge clock);
         drain_cycles++;
      end

      $display("checked %0d responses: %0d allocated, %0d skipped, %0d freed,",
               checked_count, status_seen[0], status_seen[1], status_seen[2]);
      $display("  %0d ignored, %0d not found; memory sizes 1024, 64, 65535, 1, 300",
               status_seen[3], status_seen[4]);
      if (error_count == 0 && pending_results.size() == 0)
         $display("tb_first_fit_allocator_unit passed");
      else
         $display("tb_first_fit_allocator_unit failed");
      $finish;
   end

endmodule

// File: first_fit_allocator_unit.f
src/ffa_pkg.sv
src/ffa_if.sv
src/ffa_seg_ram.sv
src/first_fit_allocator_unit.sv
test/tb_first_fit_allocator_unit.sv
